// ===== hw/rtl/tte_pkg.sv =====
package tte_pkg;

    localparam int MAX_TIMER_COUNT = 64;
    localparam int SLOT_W          = 6;
    localparam int TICK_W          = 32;

    typedef enum logic [2:0] {
        ACT_ADD    = 3'd0,
        ACT_DELETE = 3'd1,
        ACT_UPDATE = 3'd2,
        ACT_QUERY  = 3'd3,
        ACT_TICK   = 3'd4
    } action_t;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_NOFREE   = 2'd1;
    localparam logic [1:0] STAT_INACTIVE = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RUN
    } state_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [4:0]  handle;
        logic [30:0] delay;
    } cmd_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  result_handle;
        logic        expired;
        logic [31:0] remaining;
        logic        last;
    } rsp_word_t;

    // packet walking the cell chain, one cell per cycle
    typedef struct packed {
        logic              valid;
        logic [2:0]        op;
        logic              nofree;
        logic [SLOT_W-1:0] slot;
        logic [TICK_W-1:0] stamp;
        logic              found;
        logic [TICK_W-1:0] remaining;
        logic              hit;
        logic [SLOT_W-1:0] hit_slot;
    } pkt_t;

    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
    } emit_t;

endpackage

// ===== hw/rtl/tte_cell.sv =====
module tte_cell #(
    parameter int INDEX = 0
) (
    input  logic          clk,
    input  logic          rst_n,
    input  tte_pkg::pkt_t pkt_in,
    output tte_pkg::pkt_t pkt_out,
    output tte_pkg::emit_t emit
);
    import tte_pkg::*;

    logic              active_reg;
    logic              active_next;
    logic [TICK_W-1:0] expiry_reg;
    logic [TICK_W-1:0] expiry_next;
    pkt_t              pkt_reg;
    pkt_t              pkt_next;
    logic              addressed;
    logic              reached;
    logic [TICK_W-1:0] since;

    assign addressed = (pkt_in.slot == SLOT_W'(INDEX));
    assign since     = pkt_in.stamp - expiry_reg;
    assign reached   = active_reg && !since[TICK_W-1];

    always_comb
    begin
        active_next = active_reg;
        expiry_next = expiry_reg;
        pkt_next    = pkt_in;
        emit        = '0;
        if (pkt_in.valid)
        begin
            case (action_t'(pkt_in.op))
                ACT_ADD:
                begin
                    if (addressed && !pkt_in.nofree)
                    begin
                        active_next = 1'b1;
                        expiry_next = pkt_in.stamp;
                    end
                end
                ACT_DELETE:
                begin
                    if (addressed && active_reg)
                    begin
                        active_next    = 1'b0;
                        pkt_next.found = 1'b1;
                    end
                end
                ACT_UPDATE:
                begin
                    if (addressed && active_reg)
                    begin
                        expiry_next    = pkt_in.stamp;
                        pkt_next.found = 1'b1;
                    end
                end
                ACT_QUERY:
                begin
                    if (addressed && active_reg)
                    begin
                        pkt_next.found     = 1'b1;
                        pkt_next.remaining = expiry_reg - pkt_in.stamp;
                    end
                end
                ACT_TICK:
                begin
                    if (reached)
                    begin
                        active_next       = 1'b0;
                        // hand out the hit held so far, keep this one
                        emit.valid        = pkt_in.hit;
                        emit.slot         = pkt_in.hit_slot;
                        pkt_next.hit      = 1'b1;
                        pkt_next.hit_slot = SLOT_W'(INDEX);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            pkt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            pkt_reg    <= pkt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        expiry_reg <= expiry_next;
    end

    assign pkt_out = pkt_reg;

endmodule

// ===== hw/rtl/tte_chain.sv =====
module tte_chain #(
    parameter int TIMER_COUNT = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  tte_pkg::pkt_t  pkt_in,
    output tte_pkg::pkt_t  pkt_out,
    output tte_pkg::emit_t emit
);
    import tte_pkg::*;

    pkt_t  links [TIMER_COUNT+1];
    emit_t emits [TIMER_COUNT];

    assign links[0] = pkt_in;

    for (genvar g = 0; g < TIMER_COUNT; g++)
    begin : g_cell
        tte_cell #(
            .INDEX(g)
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .pkt_in (links[g]),
            .pkt_out(links[g+1]),
            .emit   (emits[g])
        );
    end

    assign pkt_out = links[TIMER_COUNT];

    // only the cell holding the packet can emit
    always_comb
    begin
        emit = '0;
        for (int i = 0; i < TIMER_COUNT; i++)
        begin
            emit.valid = emit.valid | emits[i].valid;
            emit.slot  = emit.slot | (emits[i].slot & {SLOT_W{emits[i].valid}});
        end
    end

endmodule

// ===== hw/rtl/tte_free_fifo.sv =====
module tte_free_fifo #(
    parameter int TIMER_COUNT = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           pop,
    input  logic                           push,
    input  logic [tte_pkg::SLOT_W-1:0]     push_slot,
    output logic [tte_pkg::SLOT_W-1:0]     head_slot,
    output logic [$clog2(TIMER_COUNT):0]   free_count
);
    import tte_pkg::*;

    localparam int IDX_W = $clog2(TIMER_COUNT);
    localparam int CNT_W = IDX_W + 1;

    logic [IDX_W-1:0] mem [TIMER_COUNT];
    logic [IDX_W-1:0] head_reg;
    logic [IDX_W-1:0] head_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic [IDX_W-1:0] rd_data_reg;
    logic [IDX_W-1:0] rd_head_reg;
    logic             rd_init_reg;
    logic [CNT_W:0]   tail_sum;
    logic [IDX_W-1:0] tail;
    logic             push_ok;

    assign tail_sum = (CNT_W+1)'(head_reg) + (CNT_W+1)'(count_reg);
    assign tail     = (tail_sum >= (CNT_W+1)'(TIMER_COUNT))
                    ? IDX_W'(tail_sum - (CNT_W+1)'(TIMER_COUNT))
                    : IDX_W'(tail_sum);
    assign push_ok  = push && (count_reg < CNT_W'(TIMER_COUNT));

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        fill_next  = fill_reg;
        if (pop)
        begin
            head_next  = (head_reg == IDX_W'(TIMER_COUNT - 1)) ? '0 : head_reg + 1'b1;
            count_next = count_next - 1'b1;
        end
        if (push_ok)
        begin
            count_next = count_next + 1'b1;
            if (fill_reg < CNT_W'(TIMER_COUNT))
            begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= CNT_W'(TIMER_COUNT);
            fill_reg  <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            fill_reg  <= fill_next;
        end
    end

    // tail positions are written in order from zero; unwritten ones read back as their own index
    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem[tail] <= push_slot[IDX_W-1:0];
        end
        rd_data_reg <= mem[head_reg];
        rd_head_reg <= head_reg;
        rd_init_reg <= (CNT_W'(head_reg) >= fill_reg);
    end

    assign head_slot  = SLOT_W'(rd_init_reg ? rd_head_reg : rd_data_reg);
    assign free_count = count_reg;

endmodule

// ===== hw/rtl/timer_table_expiry_engine_top.sv =====
// Results follow once start is taken, the last one flagged by rsp.last. busy
// stays high until that final word, so no new command word is taken while a
// packet walks the cell chain.
// A tick emits at most one expiry per cycle while the packet passes the cells.
// Reset: tick count zero, all timers inactive, free list holds 0..TIMER_COUNT-1.
// The receiver cannot stall; each result word is valid for one rsp_strobe cycle.
module timer_table_expiry_engine_top #(
    parameter int TIMER_COUNT = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  tte_pkg::cmd_word_t  cmd,
    output tte_pkg::rsp_word_t  rsp,
    output logic                rsp_strobe
);
    import tte_pkg::*;

    localparam int CNT_W = $clog2(TIMER_COUNT) + 1;

    state_t            state_reg;
    state_t            state_next;
    cmd_word_t         req_reg;
    cmd_word_t         req_next;
    logic [TICK_W-1:0] tick_reg;
    logic [TICK_W-1:0] tick_next;
    rsp_word_t         rsp_reg;
    rsp_word_t         rsp_next;
    logic              strobe_reg;
    logic              strobe_next;
    logic              accept;
    pkt_t              launch;
    pkt_t              chain_out;
    emit_t             chain_emit;
    logic              pop;
    logic              push;
    logic [SLOT_W-1:0] push_slot;
    logic [SLOT_W-1:0] head_slot;
    logic [CNT_W-1:0]  free_count;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    tte_free_fifo #(
        .TIMER_COUNT(TIMER_COUNT)
    ) u_free_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop       (pop),
        .push      (push),
        .push_slot (push_slot),
        .head_slot (head_slot),
        .free_count(free_count)
    );

    tte_chain #(
        .TIMER_COUNT(TIMER_COUNT)
    ) u_chain (
        .clk    (clk),
        .rst_n  (rst_n),
        .pkt_in (launch),
        .pkt_out(chain_out),
        .emit   (chain_emit)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (chain_out.valid)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_next    = accept ? cmd : req_reg;
        tick_next   = tick_reg;
        launch      = '0;
        pop         = 1'b0;
        push        = 1'b0;
        push_slot   = '0;
        rsp_next    = '0;
        strobe_next = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                launch.valid = 1'b1;
                launch.op    = req_reg.action;
                launch.slot  = SLOT_W'(req_reg.handle);
                launch.stamp = tick_reg;
                case (action_t'(req_reg.action))
                    ACT_ADD:
                    begin
                        launch.slot   = head_slot;
                        launch.stamp  = tick_reg + TICK_W'(req_reg.delay);
                        launch.nofree = (free_count == '0);
                        pop           = (free_count != '0);
                    end
                    ACT_UPDATE:
                    begin
                        launch.stamp = tick_reg + TICK_W'(req_reg.delay);
                    end
                    ACT_TICK:
                    begin
                        tick_next    = tick_reg + 1'b1;
                        launch.stamp = tick_reg + 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_RUN:
            begin
                if (chain_emit.valid)
                begin
                    strobe_next            = 1'b1;
                    rsp_next.status        = STAT_OK;
                    rsp_next.result_handle = chain_emit.slot[4:0];
                    rsp_next.expired       = 1'b1;
                    push                   = 1'b1;
                    push_slot              = chain_emit.slot;
                end
                else if (chain_out.valid)
                begin
                    strobe_next   = 1'b1;
                    rsp_next.last = 1'b1;
                    case (action_t'(chain_out.op))
                        ACT_ADD:
                        begin
                            if (chain_out.nofree)
                            begin
                                rsp_next.status = STAT_NOFREE;
                            end
                            else
                            begin
                                rsp_next.result_handle = chain_out.slot[4:0];
                            end
                        end
                        ACT_DELETE:
                        begin
                            rsp_next.result_handle = chain_out.slot[4:0];
                            if (chain_out.found)
                            begin
                                push      = 1'b1;
                                push_slot = chain_out.slot;
                            end
                            else
                            begin
                                rsp_next.status = STAT_INACTIVE;
                            end
                        end
                        ACT_UPDATE:
                        begin
                            rsp_next.result_handle = chain_out.slot[4:0];
                            rsp_next.status = chain_out.found ? STAT_OK : STAT_INACTIVE;
                        end
                        ACT_QUERY:
                        begin
                            rsp_next.result_handle = chain_out.slot[4:0];
                            if (chain_out.found)
                            begin
                                rsp_next.remaining = chain_out.remaining;
                            end
                            else
                            begin
                                rsp_next.status = STAT_INACTIVE;
                            end
                        end
                        ACT_TICK:
                        begin
                            if (chain_out.hit)
                            begin
                                rsp_next.result_handle = chain_out.hit_slot[4:0];
                                rsp_next.expired       = 1'b1;
                                push                   = 1'b1;
                                push_slot              = chain_out.hit_slot;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            tick_reg   <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            tick_reg   <= tick_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        rsp_reg <= rsp_next;
    end

    assign rsp        = rsp_reg;
    assign rsp_strobe = strobe_reg;

    a_done_with_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> rsp_strobe && rsp.last)
        else $error("busy dropped without a final result word");

    a_idle_word_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_strobe && !busy |-> rsp.last)
        else $error("non-final result word after the item completed");

    a_no_emit_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(chain_emit.valid && chain_out.valid))
        else $error("cell emit collides with chain output");

    a_free_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_count <= CNT_W'(TIMER_COUNT))
        else $error("free list count above table size");

endmodule
